// ===== design/thc_pkg.sv =====
`timescale 1ns / 1ps

package thc_pkg;

  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned SizeW   = 36;
  localparam int unsigned ProdW   = 30;

  localparam logic [31:0] HdrBytes    = 32'd36;
  localparam logic [31:0] MinOffset   = 32'd12;
  localparam logic [31:0] FileSizeRst = 32'hFFFF_FFFF;
  localparam logic [31:0] BaseReqRst  = 32'd12;

  localparam logic [31:0] WrapMax      = 32'd2;
  localparam logic [31:0] MinFilterMax = 32'd5;
  localparam logic [31:0] MagFilterMax = 32'd1;
  localparam logic [7:0]  EdgeLodMax   = 8'd1;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_HDR    = 3'd1;
  localparam logic [2:0] ERR_FIELD  = 3'd2;
  localparam logic [2:0] ERR_FORMAT = 3'd3;
  localparam logic [2:0] ERR_DATA   = 3'd4;

  localparam logic [0:0] REG_FILE_SIZE = 1'b0;
  localparam logic [0:0] REG_BASE_REQ  = 1'b1;

  localparam logic [31:0] FMT_I4     = 32'd0;
  localparam logic [31:0] FMT_I8     = 32'd1;
  localparam logic [31:0] FMT_IA4    = 32'd2;
  localparam logic [31:0] FMT_IA8    = 32'd3;
  localparam logic [31:0] FMT_RGB565 = 32'd4;
  localparam logic [31:0] FMT_RGB5A3 = 32'd5;
  localparam logic [31:0] FMT_RGBA8  = 32'd6;
  localparam logic [31:0] FMT_C4     = 32'd8;
  localparam logic [31:0] FMT_C8     = 32'd9;
  localparam logic [31:0] FMT_C14X2  = 32'd10;
  localparam logic [31:0] FMT_CMPR   = 32'd14;

  typedef struct packed {
    logic known;
    logic tw8;
    logic th8;
    logic tb64;
  } geo_t;

  typedef struct packed {
    logic [31:0] file_size;
    logic [31:0] base_required;
    logic        base_load;
  } cfg_t;

  function automatic geo_t tile_geo(input logic [31:0] fmt);
    geo_t g;
    g = '{known: 1'b1, tw8: 1'b0, th8: 1'b0, tb64: 1'b0};
    case (fmt)
      FMT_I4, FMT_C4, FMT_CMPR: begin
        g.tw8 = 1'b1;
        g.th8 = 1'b1;
      end
      FMT_I8, FMT_IA4, FMT_C8: begin
        g.tw8 = 1'b1;
      end
      FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_C14X2: begin
        g.known = 1'b1;
      end
      FMT_RGBA8: begin
        g.tb64 = 1'b1;
      end
      default: begin
        g.known = 1'b0;
      end
    endcase
    return g;
  endfunction

endpackage

// ===== design/thc_cfg_regs.sv =====
`timescale 1ns / 1ps

module thc_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [thc_pkg::AddrW-1:0] paddr,
  input  logic [thc_pkg::DataW-1:0] pwdata,
  output logic [thc_pkg::DataW-1:0] prdata,
  output logic                     pready,
  output thc_pkg::cfg_t            cfg_o
);
  import thc_pkg::*;

  logic [31:0] file_size_q;
  logic [31:0] base_req_q;
  logic        wr_en;
  logic [0:0]  reg_idx;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= FileSizeRst;
      base_req_q  <= BaseReqRst;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FILE_SIZE: file_size_q <= pwdata;
        REG_BASE_REQ:  base_req_q  <= pwdata;
        default:       file_size_q <= file_size_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FILE_SIZE: prdata = file_size_q;
      REG_BASE_REQ:  prdata = base_req_q;
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.file_size     = file_size_q;
  assign cfg_o.base_required = pwdata;
  assign cfg_o.base_load     = wr_en && (reg_idx == REG_BASE_REQ);

endmodule

// ===== design/thc_mip_sum.sv =====
`timescale 1ns / 1ps

module thc_mip_sum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [15:0]               width_i,
  input  logic [15:0]               height_i,
  input  logic [7:0]                max_lod_i,
  input  thc_pkg::geo_t             geo_i,
  output logic                      done_o,
  output logic [thc_pkg::SizeW-1:0] total_o
);
  import thc_pkg::*;

  logic             run_q;
  logic             pv_q;
  logic             done_q;
  logic [7:0]       cnt_q;
  logic [15:0]      w_q, h_q;
  logic [ProdW-1:0] prod_q;
  logic [SizeW-1:0] tot_q;

  logic [16:0]      wx, hy;
  logic [14:0]      bx, by;
  logic [SizeW-1:0] scaled;

  // tiles across and down for the current level
  assign wx = {1'b0, w_q} + (geo_i.tw8 ? 17'd7 : 17'd3);
  assign hy = {1'b0, h_q} + (geo_i.th8 ? 17'd7 : 17'd3);
  assign bx = geo_i.tw8 ? 15'(wx >> 3) : 15'(wx >> 2);
  assign by = geo_i.th8 ? 15'(hy >> 3) : 15'(hy >> 2);

  assign scaled = geo_i.tb64 ? {prod_q, 6'b0} : {1'b0, prod_q, 5'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pv_q   <= run_q;
      done_q <= pv_q && !run_q;
      if (run_q && cnt_q == 8'd0) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q <= max_lod_i;
      w_q   <= width_i;
      h_q   <= height_i;
      tot_q <= '0;
    end else begin
      if (run_q) begin
        prod_q <= {15'd0, bx} * {15'd0, by};
        w_q    <= (w_q[15:1] == 15'd0) ? 16'd1 : {1'b0, w_q[15:1]};
        h_q    <= (h_q[15:1] == 15'd0) ? 16'd1 : {1'b0, h_q[15:1]};
        cnt_q  <= cnt_q - 8'd1;
      end
      if (pv_q) begin
        tot_q <= tot_q + scaled;
      end
    end
  end

  assign done_o  = done_q;
  assign total_o = tot_q;

endmodule

// ===== design/texture_header_check_core.sv =====
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    header fields, one request
// out      output     out_valid_o / out_stall_i  ok, error_code, data_bytes, required_bytes
// cfg      input      APB (psel/penable)         file_size @0x0, base_required @0x4
//
// One request at a time through the header, field, mip and data states; a
// header placement error skips the rest, a field or format error the mip and
// data states. The mip sum issues one level per cycle through a shared
// multiplier. Reset loads file_size and the running maximum; no clearing
// pass. A pending result sits in the output register while the next request
// is accepted; the new result waits until out_stall_i drops.
`timescale 1ns / 1ps

module texture_header_check_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [thc_pkg::AddrW-1:0] paddr,
  input  logic [thc_pkg::DataW-1:0] pwdata,
  output logic [thc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [31:0]               header_offset_i,
  input  logic [15:0]               height_i,
  input  logic [15:0]               width_i,
  input  logic [31:0]               format_i,
  input  logic [31:0]               data_offset_i,
  input  logic [31:0]               wrap_s_i,
  input  logic [31:0]               wrap_t_i,
  input  logic [63:0]               filter_pair_i,
  input  logic [31:0]               lod_bias_bits_i,
  input  logic [7:0]                edge_lod_enable_i,
  input  logic [7:0]                min_lod_i,
  input  logic [7:0]                max_lod_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      ok_o,
  output logic [2:0]                error_code_o,
  output logic [thc_pkg::SizeW-1:0] data_bytes_o,
  output logic [thc_pkg::SizeW-1:0] required_bytes_o
);
  import thc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HDR   = 3'd1;
  localparam logic [2:0] ST_FIELD = 3'd2;
  localparam logic [2:0] ST_MIP   = 3'd3;
  localparam logic [2:0] ST_DATA  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  cfg_t cfg;

  logic [2:0]       state_q, state_d;
  logic [SizeW-1:0] req_q;
  logic             out_valid_q;

  logic [31:0]      hoff_q, doff_q;
  logic [15:0]      w_q, h_q;
  logic [7:0]       max_lod_q;
  geo_t             geo_q;
  logic             field_bad_q;
  logic [2:0]       err_q;
  logic [SizeW-1:0] bytes_q;

  logic             ok_q;
  logic [2:0]       err_out_q;
  logic [SizeW-1:0] bytes_out_q, req_out_q;

  logic             in_acc, out_free, mip_start, mip_done;
  logic [SizeW-1:0] mip_total;
  logic             field_bad;

  logic [31:0]      rng_off, room;
  logic [SizeW-1:0] rng_len, rng_end;
  logic             rng_pass, rng_chk;

  thc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  thc_mip_sum u_mip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mip_start),
    .width_i   (w_q),
    .height_i  (h_q),
    .max_lod_i (max_lod_q),
    .geo_i     (geo_q),
    .done_o    (mip_done),
    .total_o   (mip_total)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign field_bad = (width_i == 16'd0) || (height_i == 16'd0) ||
                     (min_lod_i > max_lod_i) || (lod_bias_bits_i[30:23] == 8'hFF) ||
                     (wrap_s_i > WrapMax) || (wrap_t_i > WrapMax) ||
                     (filter_pair_i[63:32] > MinFilterMax) ||
                     (filter_pair_i[31:0] > MagFilterMax) ||
                     (edge_lod_enable_i > EdgeLodMax);

  // shared range check: header span, later data span
  assign rng_chk  = (state_q == ST_HDR) || (state_q == ST_DATA);
  assign rng_off  = (state_q == ST_HDR) ? hoff_q : doff_q;
  assign rng_len  = (state_q == ST_HDR) ? {4'b0, HdrBytes} : bytes_q;
  assign room     = cfg.file_size - rng_off;
  assign rng_pass = (rng_off >= MinOffset) && (rng_off <= cfg.file_size) &&
                    (rng_len <= {4'b0, room});
  assign rng_end  = {4'b0, rng_off} + rng_len;

  assign mip_start = (state_q == ST_FIELD) && !field_bad_q && geo_q.known;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_HDR;
      ST_HDR:   state_d = rng_pass ? ST_FIELD : ST_DONE;
      ST_FIELD: state_d = mip_start ? ST_MIP : ST_DONE;
      ST_MIP:   if (mip_done) state_d = ST_DATA;
      ST_DATA:  state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= {4'b0, BaseReqRst};
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg.base_load) begin
        req_q <= {4'b0, cfg.base_required};
      end else if (rng_chk && rng_pass && rng_end > req_q) begin
        req_q <= rng_end;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hoff_q      <= header_offset_i;
      doff_q      <= data_offset_i;
      w_q         <= width_i;
      h_q         <= height_i;
      max_lod_q   <= max_lod_i;
      geo_q       <= tile_geo(format_i);
      field_bad_q <= field_bad;
      bytes_q     <= '0;
    end
    case (state_q)
      ST_HDR: begin
        if (!rng_pass) err_q <= ERR_HDR;
      end
      ST_FIELD: begin
        if (field_bad_q) begin
          err_q <= ERR_FIELD;
        end else if (!geo_q.known) begin
          err_q <= ERR_FORMAT;
        end
      end
      ST_MIP: begin
        if (mip_done) bytes_q <= mip_total;
      end
      ST_DATA: begin
        err_q <= rng_pass ? ERR_NONE : ERR_DATA;
      end
      ST_DONE: begin
        if (out_free) begin
          ok_q        <= (err_q == ERR_NONE);
          err_out_q   <= err_q;
          bytes_out_q <= bytes_q;
          req_out_q   <= req_q;
        end
      end
      default: begin
        err_q <= err_q;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign ok_o             = ok_q;
  assign error_code_o     = err_out_q;
  assign data_bytes_o     = bytes_out_q;
  assign required_bytes_o = req_out_q;

endmodule

// ===== test/texture_header_check_core_tb.sv =====
`timescale 1ns / 1ps

module texture_header_check_core_tb;
  import thc_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [31:0] header_offset;
    logic [15:0] height;
    logic [15:0] width;
    logic [31:0] format;
    logic [31:0] data_offset;
    logic [31:0] wrap_s;
    logic [31:0] wrap_t;
    logic [63:0] filter_pair;
    logic [31:0] lod_bias_bits;
    logic [7:0]  edge_lod_enable;
    logic [7:0]  min_lod;
    logic [7:0]  max_lod;
  } header_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  code;
    logic [35:0] data_bytes;
    logic [35:0] required;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  header_t drv = '0;

  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             ok_o;
  logic [2:0]       error_code_o;
  logic [SizeW-1:0] data_bytes_o;
  logic [SizeW-1:0] required_bytes_o;

  // shadow of the block's registers and running maximum
  logic [31:0] cfg_file_size = FileSizeRst;
  logic [31:0] cfg_base_req = BaseReqRst;
  logic [35:0] req_max = {4'd0, BaseReqRst};

  header_t     pending_headers[$];
  verdict_t    expected_verdicts[$];
  int unsigned mismatches = 0;
  int unsigned gap_in = 0;
  int unsigned hold_out = 0;
  bit          steady_in = 1'b0;
  bit          steady_out = 1'b0;
  int unsigned idle_cycles = 0;
  verdict_t    got;
  verdict_t    want;

  texture_header_check_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .header_offset_i   (drv.header_offset),
    .height_i          (drv.height),
    .width_i           (drv.width),
    .format_i          (drv.format),
    .data_offset_i     (drv.data_offset),
    .wrap_s_i          (drv.wrap_s),
    .wrap_t_i          (drv.wrap_t),
    .filter_pair_i     (drv.filter_pair),
    .lod_bias_bits_i   (drv.lod_bias_bits),
    .edge_lod_enable_i (drv.edge_lod_enable),
    .min_lod_i         (drv.min_lod),
    .max_lod_i         (drv.max_lod),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .ok_o              (ok_o),
    .error_code_o      (error_code_o),
    .data_bytes_o      (data_bytes_o),
    .required_bytes_o  (required_bytes_o)
  );

  always #5 clk_i = ~clk_i;

  // passing ranges push the running maximum up to their end
  function automatic bit claim_range(input logic [35:0] offset, input logic [35:0] length);
    logic [35:0] size;
    size = {4'd0, cfg_file_size};
    if (offset > size || length > size - offset) return 1'b0;
    if (offset + length > req_max) req_max = offset + length;
    return 1'b1;
  endfunction

  function automatic verdict_t predict_verdict(input header_t h);
    verdict_t    v;
    logic [2:0]  code;
    logic [35:0] total;
    logic        known;
    int unsigned tw, th, tb, w, ht, lvl;
    v = '0;
    code = ERR_NONE;
    total = '0;
    if (h.header_offset < MinOffset) begin
      code = ERR_HDR;
    end else if (!claim_range({4'd0, h.header_offset}, {4'd0, HdrBytes})) begin
      code = ERR_HDR;
    end else if (h.width == 0 || h.height == 0 || h.min_lod > h.max_lod ||
                 (&h.lod_bias_bits[30:23]) ||
                 h.wrap_s > WrapMax || h.wrap_t > WrapMax ||
                 h.filter_pair[63:32] > MinFilterMax ||
                 h.filter_pair[31:0] > MagFilterMax ||
                 h.edge_lod_enable > EdgeLodMax) begin
      code = ERR_FIELD;
    end else begin
      tw = 4;
      th = 4;
      tb = 32;
      known = 1'b1;
      case (h.format)
        FMT_I4, FMT_C4, FMT_CMPR: begin
          tw = 8;
          th = 8;
        end
        FMT_I8, FMT_IA4, FMT_C8: begin
          tw = 8;
        end
        FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_C14X2: begin
          known = 1'b1;
        end
        FMT_RGBA8: begin
          tb = 64;
        end
        default: begin
          known = 1'b0;
        end
      endcase
      if (!known) begin
        code = ERR_FORMAT;
      end else begin
        w = h.width;
        ht = h.height;
        for (lvl = 0; lvl <= h.max_lod; lvl++) begin
          total += 36'((w + tw - 1) / tw) * 36'((ht + th - 1) / th) * 36'(tb);
          w = (w / 2 != 0) ? w / 2 : 1;
          ht = (ht / 2 != 0) ? ht / 2 : 1;
        end
        if (h.data_offset < MinOffset) begin
          code = ERR_DATA;
        end else if (!claim_range({4'd0, h.data_offset}, total)) begin
          code = ERR_DATA;
        end
      end
    end
    v.ok = (code == ERR_NONE);
    v.code = code;
    v.data_bytes = total;
    v.required = req_max;
    return v;
  endfunction

  function automatic logic [31:0] legal_format(input int unsigned k);
    case (k)
      0: return FMT_I4;
      1: return FMT_I8;
      2: return FMT_IA4;
      3: return FMT_IA8;
      4: return FMT_RGB565;
      5: return FMT_RGB5A3;
      6: return FMT_RGBA8;
      7: return FMT_C4;
      8: return FMT_C8;
      9: return FMT_C14X2;
      default: return FMT_CMPR;
    endcase
  endfunction

  function automatic header_t plain_header();
    header_t h;
    h = '0;
    h.header_offset = MinOffset;
    h.height = 16'd8;
    h.width = 16'd8;
    h.format = FMT_I4;
    h.data_offset = 32'd48;
    return h;
  endfunction

  // legal header with random content, placed against the current file size
  function automatic header_t shaped_header();
    header_t     h;
    logic [31:0] top, near, bias;
    int unsigned pick;
    h = plain_header();
    top = (cfg_file_size >= 32'd48) ? cfg_file_size - HdrBytes : MinOffset;
    near = (top > 32'd4108) ? 32'd4108 : top;
    h.header_offset = ($urandom_range(3, 0) == 0) ? $urandom_range(top, 12)
                                                  : $urandom_range(near, 12);
    top = (cfg_file_size >= MinOffset) ? cfg_file_size : MinOffset;
    near = (top > 32'h0010_0000) ? 32'h0010_0000 : top;
    h.data_offset = ($urandom_range(3, 0) == 0) ? $urandom_range(top, 12)
                                                : $urandom_range(near, 12);
    pick = $urandom_range(9, 0);
    if (pick < 7) begin
      h.width = 16'($urandom_range(256, 1));
      h.height = 16'($urandom_range(256, 1));
    end else if (pick < 9) begin
      h.width = 16'($urandom_range(65535, 1));
      h.height = 16'($urandom_range(65535, 1));
    end else begin
      h.width = $urandom_range(1, 0) ? 16'hFFFF : 16'd1;
      h.height = $urandom_range(1, 0) ? 16'hFFFF : 16'd1;
    end
    pick = $urandom_range(19, 0);
    if (pick < 17) h.max_lod = 8'($urandom_range(12, 0));
    else if (pick < 19) h.max_lod = 8'($urandom_range(255, 0));
    else h.max_lod = 8'hFF;
    h.min_lod = 8'($urandom_range(h.max_lod, 0));
    h.format = legal_format($urandom_range(10, 0));
    h.wrap_s = $urandom_range(2, 0);
    h.wrap_t = $urandom_range(2, 0);
    h.filter_pair = {32'($urandom_range(5, 0)), 32'($urandom_range(1, 0))};
    bias = $urandom;
    if (&bias[30:23]) bias[23] = 1'b0;
    h.lod_bias_bits = bias;
    h.edge_lod_enable = 8'($urandom_range(1, 0));
    return h;
  endfunction

  task automatic run_random(input int unsigned count);
    header_t     h;
    int unsigned i, pick;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(19, 0);
      h = shaped_header();
      if (pick >= 17) begin
        h.header_offset = $urandom;
        {h.height, h.width} = $urandom;
        h.format = $urandom;
        h.data_offset = $urandom;
        h.wrap_s = $urandom;
        h.wrap_t = $urandom;
        h.filter_pair = {$urandom, $urandom};
        h.lod_bias_bits = $urandom;
        {h.edge_lod_enable, h.min_lod, h.max_lod} = 24'($urandom);
      end else if (pick >= 14) begin
        case ($urandom_range(10, 0))
          0: h.header_offset = $urandom_range(1, 0) ? $urandom_range(11, 0) : $urandom;
          1: h.width = '0;
          2: h.height = '0;
          3: h.format = $urandom_range(1, 0) ? $urandom_range(15, 7) : $urandom;
          4: h.data_offset = $urandom_range(1, 0) ? $urandom_range(11, 0) : $urandom;
          5: h.wrap_s = $urandom_range(32'hFFFF_FFFF, 3);
          6: h.wrap_t = $urandom_range(32'hFFFF_FFFF, 3);
          7: h.filter_pair = {$urandom, $urandom};
          8: h.lod_bias_bits[30:23] = 8'hFF;
          9: h.edge_lod_enable = 8'($urandom_range(255, 2));
          default: begin
            h.max_lod = 8'($urandom_range(254, 0));
            h.min_lod = 8'($urandom_range(255, h.max_lod + 1));
          end
        endcase
      end
      pending_headers.push_back(h);
    end
  endtask

  task automatic drain();
    while (pending_headers.size() != 0 || in_valid_i || expected_verdicts.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_FILE_SIZE) begin
      cfg_file_size = value;
    end else begin
      cfg_base_req = value;
      req_max = {4'd0, value};
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic report(input string what, input logic [35:0] want_v, input logic [35:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want_v, got_v);
  endtask

  function automatic int unsigned idle_draw(input bit steady);
    return steady ? 0 : $urandom_range(9, 0);
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_verdicts.push_back(predict_verdict(drv));
        if ($urandom_range(49, 0) == 0) steady_in = !steady_in;
        gap_in = idle_draw(steady_in);
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled request
      end else if (gap_in != 0) begin
        gap_in--;
        in_valid_i <= 1'b0;
      end else if (pending_headers.size() != 0) begin
        drv <= pending_headers.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {ok_o, error_code_o, data_bytes_o, required_bytes_o};
        if (expected_verdicts.size() == 0) begin
          report("result with no request pending", '0, {33'd0, got.code});
        end else begin
          want = expected_verdicts.pop_front();
          if (got.ok !== want.ok) report("ok", {35'd0, want.ok}, {35'd0, got.ok});
          if (got.code !== want.code) report("error_code", {33'd0, want.code}, {33'd0, got.code});
          if (got.data_bytes !== want.data_bytes)
            report("data_bytes", want.data_bytes, got.data_bytes);
          if (got.required !== want.required)
            report("required_bytes", want.required, got.required);
        end
        if ($urandom_range(49, 0) == 0) steady_out = !steady_out;
        hold_out = idle_draw(steady_out);
      end else if (hold_out != 0) begin
        hold_out--;
      end
      out_stall_i <= (hold_out != 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    header_t     h;
    int unsigned k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: every format, field limits, each error class
    for (k = 0; k < 11; k++) begin
      h = plain_header();
      h.format = legal_format(k);
      h.width = 16'd5;
      h.height = 16'd3;
      h.max_lod = 8'(k);
      if (k % 2 == 0) begin
        h.min_lod = 8'(k);
        h.wrap_s = WrapMax;
        h.wrap_t = WrapMax;
        h.filter_pair = {MinFilterMax, MagFilterMax};
        h.edge_lod_enable = EdgeLodMax;
        h.lod_bias_bits = 32'hFF7F_FFFF;
      end
      pending_headers.push_back(h);
    end
    h = plain_header(); h.header_offset = 32'd11;           pending_headers.push_back(h);
    h = plain_header(); h.header_offset = 32'hFFFF_FFFF;    pending_headers.push_back(h);
    h = plain_header(); h.width = '0;                       pending_headers.push_back(h);
    h = plain_header(); h.height = '0;                      pending_headers.push_back(h);
    h = plain_header(); h.min_lod = 8'd1;                   pending_headers.push_back(h);
    h = plain_header(); h.lod_bias_bits = 32'h7F80_0000;    pending_headers.push_back(h);
    h = plain_header(); h.wrap_s = 32'd3;                   pending_headers.push_back(h);
    h = plain_header(); h.wrap_t = 32'hFFFF_FFFF;           pending_headers.push_back(h);
    h = plain_header(); h.filter_pair = {32'd6, 32'd0};     pending_headers.push_back(h);
    h = plain_header(); h.filter_pair = {32'd0, 32'd2};     pending_headers.push_back(h);
    h = plain_header(); h.edge_lod_enable = 8'd2;           pending_headers.push_back(h);
    h = plain_header(); h.format = 32'd7;                   pending_headers.push_back(h);
    h = plain_header(); h.data_offset = 32'd11;             pending_headers.push_back(h);
    h = plain_header();
    h.width = 16'hFFFF;
    h.height = 16'hFFFF;
    h.format = FMT_RGBA8;
    h.max_lod = 8'hFF;
    h.data_offset = 32'hFFFF_FFFF;
    pending_headers.push_back(h);
    h = plain_header(); h.header_offset = 32'hFFFF_FFFF - HdrBytes; pending_headers.push_back(h);
    drain();

    // tiny file: header and data ending exactly at the last byte
    write_reg(REG_FILE_SIZE, 32'd80);
    write_reg(REG_BASE_REQ, BaseReqRst);
    h = plain_header(); h.header_offset = 32'd44; h.width = 16'd1; h.height = 16'd1;
    pending_headers.push_back(h);
    h.data_offset = 32'd49;
    pending_headers.push_back(h);
    h.header_offset = 32'd45;
    pending_headers.push_back(h);
    run_random(60);
    drain();

    write_reg(REG_FILE_SIZE, 32'd0);
    run_random(30);
    drain();

    write_reg(REG_FILE_SIZE, 32'hFFFF_FFFF);
    write_reg(REG_BASE_REQ, 32'hFFFF_FFFF);
    run_random(150);
    drain();

    for (k = 0; k < 6; k++) begin
      case ($urandom_range(3, 0))
        0: write_reg(REG_FILE_SIZE, 32'hFFFF_FFFF);
        1: write_reg(REG_FILE_SIZE, $urandom);
        2: write_reg(REG_FILE_SIZE, $urandom_range(100000, 48));
        default: write_reg(REG_FILE_SIZE, $urandom_range(32'h0100_0000, 32'h0001_0000));
      endcase
      write_reg(REG_BASE_REQ, ($urandom_range(3, 0) == 0) ? 32'hFFFF_FFFF
                                                          : $urandom_range(4096, 12));
      run_random(140);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
